FILE: src/icf_pkg.sv
// shared types, constants and functions of the imu complementary filter
package icf_pkg;

  localparam int unsigned CordicIterDefault = 16;

  localparam logic signed [31:0] Deg180 = 32'sd11796480;
  localparam logic signed [31:0] Deg90 = 32'sd5898240;

  localparam logic [1:0] RegGyroScale = 2'd0;
  localparam logic [1:0] RegSamplePeriod = 2'd1;
  localparam logic [1:0] RegBlendAlpha = 2'd2;

  localparam logic [31:0] GyroScaleReset = 32'd16777216;
  localparam logic [24:0] SamplePeriodReset = 25'd16777;
  localparam logic [16:0] BlendAlphaReset = 17'd64225;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic cordic_init;
    logic cordic_step;
    logic gyro_mul;
    logic gyro_acc;
    logic blend_mul;
    logic finish;
    logic [4:0] step;
    logic [1:0] axis;
  } icf_cmd_t;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd2949120;
      5'd1: v = 32'sd1740967;
      5'd2: v = 32'sd919879;
      5'd3: v = 32'sd466945;
      5'd4: v = 32'sd234379;
      5'd5: v = 32'sd117304;
      5'd6: v = 32'sd58666;
      5'd7: v = 32'sd29335;
      5'd8: v = 32'sd14668;
      5'd9: v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/icf_ctrl.sv
// sequencer that walks one sample through sqrt, cordic, gyro and blend steps
module icf_ctrl #(
  parameter int unsigned CordicIterations = icf_pkg::CordicIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output icf_pkg::icf_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSqrt   = 7'b0000010,
    StCInit  = 7'b0000100,
    StCordic = 7'b0001000,
    StGyro   = 7'b0010000,
    StBlend  = 7'b0100000,
    StOut    = 7'b1000000
  } state_e;

  localparam int unsigned CordicLast = CordicIterations - 1;

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [1:0] sub_q, sub_d;
  logic out_valid_q, out_valid_d;

  // free when result taken or leaving this cycle
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    sub_d = sub_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.step = step_q;
    cmd_o.axis = sub_q;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StSqrt;
          step_d = 5'd15;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        step_d = step_q - 5'd1;
        if (step_q == 5'd0) begin
          state_d = StCInit;
          step_d = '0;
        end
      end
      StCInit: begin
        cmd_o.cordic_init = 1'b1;
        state_d = StCordic;
      end
      StCordic: begin
        cmd_o.cordic_step = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == 5'(CordicLast)) begin
          state_d = StGyro;
          step_d = '0;
          sub_d = '0;
        end
      end
      StGyro: begin
        // step 0 multiply, step 1 accumulate, per axis
        if (step_q == 5'd0) begin
          cmd_o.gyro_mul = 1'b1;
          step_d = 5'd1;
        end else begin
          cmd_o.gyro_acc = 1'b1;
          step_d = 5'd0;
          sub_d = sub_q + 2'd1;
          if (sub_q == 2'd2) begin
            state_d = StBlend;
            sub_d = '0;
          end
        end
      end
      StBlend: begin
        cmd_o.blend_mul = 1'b1;
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd1) begin
          state_d = StOut;
          sub_d = '0;
        end
      end
      StOut: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q <= '0;
      sub_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      sub_q <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/icf_datapath.sv
// angle state, sqrt, shared two-lane cordic, gyro integration and blend
module icf_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  icf_pkg::icf_cmd_t   cmd_i,
  input  logic [95:0]         in_data_i,
  input  logic [31:0]         gyro_scale_i,
  input  logic [24:0]         sample_period_i,
  input  logic [16:0]         blend_alpha_i,
  output logic signed [31:0]  pitch_o,
  output logic signed [31:0]  roll_o,
  output logic signed [24:0]  yaw_o,
  output logic signed [23:0]  accel_pitch_o,
  output logic signed [24:0]  accel_roll_o
);

  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [15:0] g_q [3];
  logic [31:0] n_q;
  logic [15:0] r_q;

  // two cordic lanes: 0 pitch, 1 roll
  logic signed [35:0] cx_q [2];
  logic signed [35:0] cy_q [2];
  logic signed [31:0] cz_q [2];
  logic               cnz_q [2];

  logic signed [31:0] pitch_q, roll_q, yaw_q;
  logic [47:0] m_q;
  logic        msign_q;
  logic [12:0] ymid_q;
  logic [18:0] ylo_q;
  logic signed [31:0] acc_p_q, acc_r_q;
  logic signed [31:0] out_pitch_q, out_roll_q, out_yaw_q;
  logic signed [31:0] out_ap_q, out_ar_q;

  // sqrt trial
  logic [15:0] r_try;
  logic [31:0] r_sq;
  assign r_try = r_q | (16'd1 << cmd_i.step[3:0]);
  assign r_sq = r_try * r_try;

  // cordic lane inputs
  logic signed [16:0] lane_y [2];
  logic signed [16:0] lane_x [2];
  assign lane_y[0] = -17'(ax_q);
  assign lane_x[0] = {1'b0, r_q};
  assign lane_y[1] = 17'(ay_q);
  assign lane_x[1] = 17'(az_q);

  // gyro delta path
  logic signed [48:0] gp;
  logic [47:0] gmag;
  assign gp = $signed(g_q[cmd_i.axis]) * $signed({1'b0, gyro_scale_i});
  assign gmag = gp[48] ? 48'(-gp) : gp[47:0];
  logic [72:0] prod;
  logic [40:0] q_abs;
  logic signed [41:0] delta;
  assign prod = m_q * sample_period_i;
  assign q_abs = prod[72:32];
  assign delta = msign_q ? -$signed({1'b0, q_abs}) : $signed({1'b0, q_abs});

  logic signed [42:0] sum_sat;
  logic signed [31:0] sat_val;
  logic signed [31:0] cur_ang;
  assign cur_ang = (cmd_i.axis == 2'd0) ? pitch_q : roll_q;
  assign sum_sat = 43'(cur_ang) + 43'(delta);
  assign sat_val = (sum_sat > 43'sd2147483647) ? 32'sh7fffffff :
                   (sum_sat < -43'sd2147483648) ? 32'sh80000000 : sum_sat[31:0];

  // yaw wrap: 360 degrees is 45 * 2^19 and 2^12 is 1 mod 45, so fold the
  // upper bits, then strip multiples of 45 during the pitch and roll blend commands
  localparam logic signed [42:0] Deg180x = 43'sd11796480;
  localparam logic [24:0] YawBias = 25'd8388630;
  logic signed [42:0] ysum;
  logic [24:0] ypos;
  logic [13:0] yfold1;
  logic [12:0] yfold2;
  assign ysum = 43'(yaw_q) + 43'(delta) + Deg180x;
  assign ypos = {ysum[42], ysum[42:19]} + YawBias;
  assign yfold1 = 14'(ypos[24:12]) + 14'(ypos[11:0]);
  assign yfold2 = 13'(yfold1[13:12]) + 13'(yfold1[11:0]);

  logic [12:0] yr0, yr1, yr2, yr3;
  assign yr0 = (ymid_q >= 13'd2880) ? ymid_q - 13'd2880 : ymid_q;
  assign yr1 = (yr0 >= 13'd1440) ? yr0 - 13'd1440 : yr0;
  assign yr2 = (yr1 >= 13'd720) ? yr1 - 13'd720 : yr1;
  assign yr3 = (yr2 >= 13'd360) ? yr2 - 13'd360 : yr2;

  logic [12:0] ys0, ys1, ys2;
  logic signed [31:0] ywrap;
  assign ys0 = (ymid_q >= 13'd180) ? ymid_q - 13'd180 : ymid_q;
  assign ys1 = (ys0 >= 13'd90) ? ys0 - 13'd90 : ys0;
  assign ys2 = (ys1 >= 13'd45) ? ys1 - 13'd45 : ys1;
  assign ywrap = $signed({7'b0, ys2[5:0], ylo_q}) - icf_pkg::Deg180;

  // blend
  logic [16:0] a_cl;
  logic signed [18:0] a_s, na_s;
  assign a_cl = (blend_alpha_i > 17'd65536) ? 17'd65536 : blend_alpha_i;
  assign a_s = 19'($signed({2'b0, a_cl}));
  assign na_s = 19'sd65536 - a_s;
  logic signed [31:0] b_ang, b_acc;
  assign b_ang = cmd_i.axis[0] ? roll_q : pitch_q;
  assign b_acc = cmd_i.axis[0] ? acc_r_q : acc_p_q;
  logic signed [51:0] bsum;
  assign bsum = b_ang * a_s + b_acc * na_s + 52'sd32768;
  logic signed [35:0] bsh;
  assign bsh = 36'(bsum >>> 16);
  logic signed [31:0] bsat;
  assign bsat = (bsh > 36'sd2147483647) ? 32'sh7fffffff :
                (bsh < -36'sd2147483648) ? 32'sh80000000 : bsh[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      roll_q <= '0;
      yaw_q <= '0;
    end else begin
      if (cmd_i.gyro_acc) begin
        case (cmd_i.axis)
          2'd0: pitch_q <= sat_val;
          2'd1: roll_q <= sat_val;
          default: ;
        endcase
      end
      if (cmd_i.blend_mul) begin
        if (cmd_i.axis[0]) begin
          roll_q <= bsat;
          yaw_q <= ywrap;
        end else begin
          pitch_q <= bsat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= in_data_i[15:0];
      ay_q <= in_data_i[31:16];
      az_q <= in_data_i[47:32];
      g_q[0] <= in_data_i[63:48];
      g_q[1] <= in_data_i[79:64];
      g_q[2] <= in_data_i[95:80];
      n_q <= $signed(in_data_i[31:16]) * $signed(in_data_i[31:16])
           + $signed(in_data_i[47:32]) * $signed(in_data_i[47:32]);
      r_q <= '0;
    end
    if (cmd_i.sqrt_step && r_sq <= n_q) r_q <= r_try;
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.cordic_init) begin
        cnz_q[l] <= (lane_x[l] == 0) && (lane_y[l] == 0);
        if (lane_x[l] < 0) begin
          cz_q[l] <= (lane_y[l] >= 0) ? icf_pkg::Deg180 : -icf_pkg::Deg180;
          cx_q[l] <= 36'(-lane_x[l]) <<< 16;
          cy_q[l] <= 36'(-lane_y[l]) <<< 16;
        end else begin
          cz_q[l] <= '0;
          cx_q[l] <= 36'(lane_x[l]) <<< 16;
          cy_q[l] <= 36'(lane_y[l]) <<< 16;
        end
      end
      if (cmd_i.cordic_step) begin
        if (cy_q[l] >= 0) begin
          cx_q[l] <= cx_q[l] + (cy_q[l] >>> cmd_i.step);
          cy_q[l] <= cy_q[l] - (cx_q[l] >>> cmd_i.step);
          cz_q[l] <= cz_q[l] + icf_pkg::atan_deg(cmd_i.step);
        end else begin
          cx_q[l] <= cx_q[l] - (cy_q[l] >>> cmd_i.step);
          cy_q[l] <= cy_q[l] + (cx_q[l] >>> cmd_i.step);
          cz_q[l] <= cz_q[l] - icf_pkg::atan_deg(cmd_i.step);
        end
      end
    end
    if (cmd_i.gyro_mul) begin
      m_q <= gmag;
      msign_q <= gp[48];
      acc_p_q <= cnz_q[0] ? '0 :
                 (cz_q[0] > icf_pkg::Deg90) ? icf_pkg::Deg90 :
                 (cz_q[0] < -icf_pkg::Deg90) ? -icf_pkg::Deg90 : cz_q[0];
      acc_r_q <= cnz_q[1] ? '0 :
                 (cz_q[1] > icf_pkg::Deg180) ? icf_pkg::Deg180 :
                 (cz_q[1] < -icf_pkg::Deg180) ? -icf_pkg::Deg180 : cz_q[1];
    end
    if (cmd_i.gyro_acc && cmd_i.axis == 2'd2) begin
      ymid_q <= yfold2;
      ylo_q <= ysum[18:0];
    end
    if (cmd_i.blend_mul && !cmd_i.axis[0]) ymid_q <= yr3;
    if (cmd_i.finish) begin
      out_pitch_q <= pitch_q;
      out_roll_q <= roll_q;
      out_yaw_q <= yaw_q;
      out_ap_q <= acc_p_q;
      out_ar_q <= acc_r_q;
    end
  end

  assign pitch_o = out_pitch_q;
  assign roll_o = out_roll_q;
  assign yaw_o = out_yaw_q[24:0];
  assign accel_pitch_o = out_ap_q[23:0];
  assign accel_roll_o = out_ar_q[24:0];

endmodule

FILE: src/imu_complementary_filter.sv
// imu complementary filter top level: config registers, controller, datapath
// a word is taken in the idle state, then passes the sqrt steps, the cordic init, the
// cordic iterations, gyro multiply and accumulate per axis, pitch and roll blend and output
// one sample in flight: a word is taken only in the idle state
// a result still waiting when the next is done holds the sequencer in its output state; no word is taken meanwhile
// reset clears angles to zero and loads default config values
module imu_complementary_filter #(
  parameter int unsigned CordicIterations = icf_pkg::CordicIterDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // pitch_out, roll_out, yaw_out, accel_pitch, accel_roll
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0] gyro_scale_q;
  logic [24:0] sample_period_q;
  logic [16:0] blend_alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_scale_q <= icf_pkg::GyroScaleReset;
      sample_period_q <= icf_pkg::SamplePeriodReset;
      blend_alpha_q <= icf_pkg::BlendAlphaReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        icf_pkg::RegGyroScale: gyro_scale_q <= cfg_data_i;
        icf_pkg::RegSamplePeriod: sample_period_q <= cfg_data_i[24:0];
        icf_pkg::RegBlendAlpha: blend_alpha_q <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  icf_pkg::icf_cmd_t cmd;
  logic signed [31:0] pitch, roll;
  logic signed [24:0] yaw, acc_r;
  logic signed [23:0] acc_p;

  icf_ctrl #(.CordicIterations(CordicIterations)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd)
  );

  icf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_data_i(s_axis_tdata),
    .gyro_scale_i(gyro_scale_q), .sample_period_i(sample_period_q),
    .blend_alpha_i(blend_alpha_q),
    .pitch_o(pitch), .roll_o(roll), .yaw_o(yaw),
    .accel_pitch_o(acc_p), .accel_roll_o(acc_r)
  );

  assign m_axis_tdata = {6'b0, acc_r, acc_p, yaw, roll, pitch};

endmodule

FILE: tb/sv/imu_complementary_filter_test.sv
// self-checking testbench of the imu complementary filter with a built-in attitude predictor
module imu_complementary_filter_test;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned CordicSteps = 16;
  localparam longint Deg180L = 64'sd11796480;
  localparam longint Deg90L = 64'sd5898240;
  localparam longint Deg360L = 64'sd23592960;
  localparam longint Int32Min = -64'sd2147483648;
  localparam longint Int32Max = 64'sd2147483647;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct packed {
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [24:0] yaw;
    logic [23:0] acc_pitch;
    logic [24:0] acc_roll;
  } attitude_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // pitch_out, roll_out, yaw_out, accel_pitch, accel_roll
  logic         cfg_we_i;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  imu_complementary_filter dut (.*);

  // predictor state and configuration
  longint    pitch_st, roll_st, yaw_st;
  logic [31:0] scale_cfg;
  logic [24:0] period_cfg;
  logic [16:0] alpha_cfg;

  attitude_t expected_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned stall_len;
  int unsigned stall_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r;
    longint t;
    r = 0;
    for (int i = 15; i >= 0; i--) begin
      t = r | (64'sd1 << i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? Deg180L : -Deg180L;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(icf_pkg::atan_deg(i[4:0]));
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(icf_pkg::atan_deg(i[4:0]));
      end
    end
    return z;
  endfunction

  function automatic longint rate_step(logic signed [15:0] g);
    longint p;
    longint m;
    logic [127:0] prod;
    p = longint'(g) * longint'({32'd0, scale_cfg});
    m = p < 0 ? -p : p;
    prod = 128'(m) * 128'(period_cfg);
    prod = prod >> 32;
    return p < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint fuse(longint ang, longint acc);
    longint a;
    a = alpha_cfg > 17'd65536 ? 64'sd65536 : longint'(alpha_cfg);
    return clamp64((ang * a + acc * (65536 - a) + 32768) >>> 16, Int32Min, Int32Max);
  endfunction

  function automatic attitude_t predict_attitude(imu_sample_t s);
    attitude_t r;
    longint mag;
    longint pacc;
    longint racc;
    longint t;
    mag = floor_sqrt(longint'(s.ay) * s.ay + longint'(s.az) * s.az);
    pacc = clamp64(angle_of(-longint'(s.ax), mag), -Deg90L, Deg90L);
    racc = clamp64(angle_of(longint'(s.ay), longint'(s.az)), -Deg180L, Deg180L);
    pitch_st = clamp64(pitch_st + rate_step(s.gx), Int32Min, Int32Max);
    roll_st = clamp64(roll_st + rate_step(s.gy), Int32Min, Int32Max);
    t = (yaw_st + rate_step(s.gz) + Deg180L) % Deg360L;
    if (t < 0) t += Deg360L;
    yaw_st = t - Deg180L;
    pitch_st = fuse(pitch_st, pacc);
    roll_st = fuse(roll_st, racc);
    r.pitch = pitch_st[31:0];
    r.roll = roll_st[31:0];
    r.yaw = yaw_st[24:0];
    r.acc_pitch = pacc[23:0];
    r.acc_roll = racc[24:0];
    return r;
  endfunction

  task automatic send_sample(imu_sample_t s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s.gz, s.gy, s.gx, s.az, s.ay, s.ax};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(predict_attitude(s));
  endtask

  task automatic idle_sender(int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      icf_pkg::RegGyroScale: scale_cfg = val;
      icf_pkg::RegSamplePeriod: period_cfg = val[24:0];
      icf_pkg::RegBlendAlpha: alpha_cfg = val[16:0];
      default: ;
    endcase
  endtask

  function automatic imu_sample_t mk(int ax, int ay, int az, int gx, int gy, int gz);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.gz = 16'(gz);
    return s;
  endfunction

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    if ($urandom_range(0, 3) != 0) begin
      // near-level device with noise and modest rotation rates
      s.ax = 16'($urandom_range(0, 8000) - 4000);
      s.ay = 16'($urandom_range(0, 8000) - 4000);
      s.az = 16'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 4000) - 2000);
      s.gx = 16'($urandom_range(0, 4000) - 2000);
      s.gy = 16'($urandom_range(0, 4000) - 2000);
      s.gz = 16'($urandom_range(0, 4000) - 2000);
    end else begin
      s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
      s.gx = 16'($urandom); s.gy = 16'($urandom); s.gz = 16'($urandom);
    end
    return s;
  endfunction

  task automatic test_directed();
    send_sample(mk(0, 0, 0, 0, 0, 0));
    send_sample(mk(-32768, 0, 0, 32767, -32768, 32767));
    send_sample(mk(32767, 0, 0, -32768, 32767, -32768));
    send_sample(mk(0, 0, -32768, 0, 0, 0));
    send_sample(mk(0, -1, -32768, 0, 0, 0));
    send_sample(mk(0, 32767, 0, 0, 0, 0));
    send_sample(mk(0, -32768, 0, 0, 0, 0));
    send_sample(mk(-32768, -32768, -32768, -1, -1, -1));
    send_sample(mk(32767, 32767, 32767, 1, 1, 1));
    send_sample(mk(0, 0, 16384, 100, -100, 30000));
    send_sample(mk(-1, -1, -1, -32768, -32768, -32768));
    send_sample(mk(16384, 0, 1, 0, 0, 0));
    wait_drain();
  endtask

  task automatic test_config_extremes();
    write_reg(icf_pkg::RegGyroScale, 32'hFFFF_FFFF);
    write_reg(icf_pkg::RegSamplePeriod, 32'h01FF_FFFF);
    write_reg(icf_pkg::RegBlendAlpha, 32'h0001_0000);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    // drive pitch and roll into saturation and yaw through many wraps
    repeat (4) send_sample(mk(0, 0, 16384, 32767, 32767, 32767));
    repeat (4) send_sample(mk(0, 0, 16384, -32768, -32768, -32768));
    wait_drain();
    write_reg(icf_pkg::RegBlendAlpha, 32'h0001_FFFF);
    repeat (3) send_sample(mk(1000, -2000, 16000, 32767, -32768, 12345));
    wait_drain();
    write_reg(icf_pkg::RegBlendAlpha, 32'd0);
    write_reg(icf_pkg::RegGyroScale, 32'd0);
    write_reg(icf_pkg::RegSamplePeriod, 32'd0);
    repeat (3) send_sample(mk(-20000, 5000, -9000, 32767, 32767, 32767));
    wait_drain();
  endtask

  task automatic test_random();
    int unsigned burst;
    logic [31:0] cfg_sets[3][4];
    cfg_sets = '{'{32'h0100_0000, 32'h0000_4189, 32'h0000_FAE1, 32'h0},
                 '{32'h0400_0000, 32'h0010_0000, 32'h0000_8000, 32'h0},
                 '{32'h8000_0001, 32'h01AA_5555, 32'h0001_5555, 32'h0}};
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(icf_pkg::RegGyroScale, cfg_sets[ph][0]);
      write_reg(icf_pkg::RegSamplePeriod, cfg_sets[ph][1]);
      write_reg(icf_pkg::RegBlendAlpha, cfg_sets[ph][2]);
      for (int n = 0; n < 140; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++) begin
          send_sample(rand_sample());
          n++;
        end
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 60));
        if (n > 60 && n < 60 + burst) wait_drain();
      end
      wait_drain();
    end
  endtask

  always @(posedge clk_i) begin
    attitude_t exp_r;
    attitude_t got;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (stall_len == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_len <= $urandom_range(5, 60);
    end else begin
      stall_len <= stall_len - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pitch = m_axis_tdata[31:0];
      got.roll = m_axis_tdata[63:32];
      got.yaw = m_axis_tdata[88:64];
      got.acc_pitch = m_axis_tdata[112:89];
      got.acc_roll = m_axis_tdata[137:113];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp p=%h r=%h y=%h ap=%h ar=%h got p=%h r=%h y=%h ap=%h ar=%h",
                     exp_r.pitch, exp_r.roll, exp_r.yaw, exp_r.acc_pitch, exp_r.acc_roll,
                     got.pitch, got.roll, got.yaw, got.acc_pitch, got.acc_roll);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = icf_pkg::RegGyroScale;
    cfg_data_i = '0;
    cycles = 0;
    stall_len = 0;
    stall_mode = 0;
    mismatches = 0;
    pitch_st = 0; roll_st = 0; yaw_st = 0;
    scale_cfg = icf_pkg::GyroScaleReset;
    period_cfg = icf_pkg::SamplePeriodReset;
    alpha_cfg = icf_pkg::BlendAlphaReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random();
    wait_drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
